// ===== design/ects_pkg.sv =====
// ----------------------------------------------------------------------------
// Engine coolant thermal step package
// Shared widths, register indexes, datapath operations and controller types.
// ----------------------------------------------------------------------------
package ects_pkg;

	localparam int SPEED_W = 14;
	localparam int THR_W   = 16;
	localparam int STEP_W  = 16;
	localparam int TEMP_W  = 17;
	localparam int RATE_W  = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 17;

	// Multiplier operand and product widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Load division: 16 quotient bits
	localparam int DIV_STEPS = 16;

	// 0.3 and 0.7 in Q16
	localparam logic [MUL_A_W-1:0] K_LOAD_SQ  = 32'd19661;
	localparam logic [MUL_A_W-1:0] K_LOAD_THR = 32'd45875;

	localparam logic signed [TEMP_W-1:0] TEMP_TOP = 17'sd65535;
	localparam int HYST_DEG = 5;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_AMBIENT  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_HEAT     = 3'd1;
	localparam logic [ADDR_W-1:0] REG_COOL     = 3'd2;
	localparam logic [ADDR_W-1:0] REG_LIMIT    = 3'd3;
	localparam logic [ADDR_W-1:0] REG_IDLE     = 3'd4;
	localparam logic [ADDR_W-1:0] REG_REDLINE  = 3'd5;

	// Reset values
	localparam logic signed [TEMP_W-1:0] AMBIENT_RST = 17'sd5120;
	localparam logic [RATE_W-1:0] HEAT_RST    = 16'd512;
	localparam logic [RATE_W-1:0] COOL_RST    = 16'd1311;
	localparam logic signed [TEMP_W-1:0] LIMIT_RST = 17'sd28160;
	localparam logic [SPEED_W-1:0] IDLE_RST    = 14'd800;
	localparam logic [SPEED_W-1:0] REDLINE_RST = 14'd6500;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_SETUP,
		OP_DIV,
		OP_LL,
		OP_LT,
		OP_H0,
		OP_H1,
		OP_SR,
		OP_HT,
		OP_X,
		OP_P,
		OP_ROM0,
		OP_ROM1,
		OP_DIFF,
		OP_FRAC,
		OP_DEC,
		OP_UPD,
		OP_FLAG,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SETUP,
		S_DIV,
		S_LL,
		S_LT,
		S_H0,
		S_H1,
		S_SR,
		S_HT,
		S_X,
		S_P,
		S_ROM0,
		S_ROM1,
		S_DIFF,
		S_FRAC,
		S_DEC,
		S_UPD,
		S_FLAG,
		S_OUT
	} state_t;

	typedef struct packed {
		logic step_zero;
		logic need_div;
	} status_t;

endpackage

// ===== design/ects_if.sv =====
// ----------------------------------------------------------------------------
// Engine coolant thermal step channels
// Sample, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ects_sample_if;
	logic                            valid;
	logic                            ready;
	logic [ects_pkg::SPEED_W-1:0]    engine_speed;
	logic [ects_pkg::THR_W-1:0]      throttle_pos;
	logic [ects_pkg::STEP_W-1:0]     step_time;

	modport source (output valid, engine_speed, throttle_pos, step_time, input ready);
	modport sink   (input valid, engine_speed, throttle_pos, step_time, output ready);
endinterface

interface ects_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [ects_pkg::TEMP_W-1:0]  coolant_temp;
	logic                                overheat_flag;

	modport source (output valid, coolant_temp, overheat_flag, input ready);
	modport sink   (input valid, coolant_temp, overheat_flag, output ready);
endinterface

interface ects_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ects_pkg::ADDR_W-1:0]   addr;
	logic [ects_pkg::DATA_W-1:0]   data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// ===== design/ects_ctrl.sv =====
// ----------------------------------------------------------------------------
// Engine coolant thermal step controller
// Sequences one step through the shared multiplier datapath.
// ----------------------------------------------------------------------------
module ects_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ects_pkg::status_t  status,
	output ects_pkg::op_t      op
);

	localparam int CNT_W = $clog2(ects_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ects_pkg::DIV_STEPS - 1);

	ects_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ects_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ects_pkg::S_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = ects_pkg::OP_NONE;
		out_load = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ects_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = ects_pkg::OP_CAPTURE;
					state_d = ects_pkg::S_SETUP;
				end
			end
			ects_pkg::S_SETUP: begin
				op = ects_pkg::OP_SETUP;
				if (status.step_zero)
					state_d = ects_pkg::S_OUT;
				else if (status.need_div)
					state_d = ects_pkg::S_DIV;
				else
					state_d = ects_pkg::S_LL;
			end
			ects_pkg::S_DIV: begin
				op = ects_pkg::OP_DIV;
				if (cnt_q == DIV_LAST)
					state_d = ects_pkg::S_LL;
			end
			ects_pkg::S_LL: begin
				op = ects_pkg::OP_LL; state_d = ects_pkg::S_LT;
			end
			ects_pkg::S_LT: begin
				op = ects_pkg::OP_LT; state_d = ects_pkg::S_H0;
			end
			ects_pkg::S_H0: begin
				op = ects_pkg::OP_H0; state_d = ects_pkg::S_H1;
			end
			ects_pkg::S_H1: begin
				op = ects_pkg::OP_H1; state_d = ects_pkg::S_SR;
			end
			ects_pkg::S_SR: begin
				op = ects_pkg::OP_SR; state_d = ects_pkg::S_HT;
			end
			ects_pkg::S_HT: begin
				op = ects_pkg::OP_HT; state_d = ects_pkg::S_X;
			end
			ects_pkg::S_X: begin
				op = ects_pkg::OP_X; state_d = ects_pkg::S_P;
			end
			ects_pkg::S_P: begin
				op = ects_pkg::OP_P; state_d = ects_pkg::S_ROM0;
			end
			ects_pkg::S_ROM0: begin
				op = ects_pkg::OP_ROM0; state_d = ects_pkg::S_ROM1;
			end
			ects_pkg::S_ROM1: begin
				op = ects_pkg::OP_ROM1; state_d = ects_pkg::S_DIFF;
			end
			ects_pkg::S_DIFF: begin
				op = ects_pkg::OP_DIFF; state_d = ects_pkg::S_FRAC;
			end
			ects_pkg::S_FRAC: begin
				op = ects_pkg::OP_FRAC; state_d = ects_pkg::S_DEC;
			end
			ects_pkg::S_DEC: begin
				op = ects_pkg::OP_DEC; state_d = ects_pkg::S_UPD;
			end
			ects_pkg::S_UPD: begin
				op = ects_pkg::OP_UPD; state_d = ects_pkg::S_FLAG;
			end
			ects_pkg::S_FLAG: begin
				op = ects_pkg::OP_FLAG; state_d = ects_pkg::S_OUT;
			end
			ects_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					op       = ects_pkg::OP_OUT;
					out_load = 1'b1;
					state_d  = ects_pkg::S_IDLE;
				end
			end
			default: state_d = ects_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ects_pkg::S_SETUP)
		else $error("accepted request did not start setup");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ects_pkg::S_DIV && cnt_q == DIV_LAST |=> state_q == ects_pkg::S_LL)
		else $error("divide did not end after all quotient bits");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ects_pkg::S_OUT && (!out_valid_q || out_ready)
		|=> out_valid_q && state_q == ects_pkg::S_IDLE)
		else $error("result not posted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !out_load)
		else $error("pending result overwritten");

endmodule

// ===== design/ects_dp.sv =====
// ----------------------------------------------------------------------------
// Engine coolant thermal step datapath
// Registers, load divider, shared multiplier and decay table.
// ----------------------------------------------------------------------------
module ects_dp #(
	parameter int EXP_TABLE_SIZE = 256,
	parameter int TEMP_FRAC_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ects_pkg::op_t                        op,
	output ects_pkg::status_t                    status,
	input  logic [ects_pkg::SPEED_W-1:0]         engine_speed,
	input  logic [ects_pkg::THR_W-1:0]           throttle_pos,
	input  logic [ects_pkg::STEP_W-1:0]          step_time,
	input  logic                                 cfg_we,
	input  logic [ects_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [ects_pkg::DATA_W-1:0]          cfg_data,
	output logic signed [ects_pkg::TEMP_W-1:0]   coolant_temp,
	output logic                                 overheat_flag
);

	localparam int AW = $clog2(EXP_TABLE_SIZE + 1);
	localparam int TW = ects_pkg::TEMP_W;
	localparam int PW = ects_pkg::PROD_W;
	localparam logic signed [19:0] HYST = 20'(ects_pkg::HYST_DEG << TEMP_FRAC_BITS);

	typedef logic [16:0] tab_t [0:EXP_TABLE_SIZE];

	// Shift-subtract quotient, evaluated only while the table is built
	function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-i/N) in Q16 from a truncated 25-term series in Q30
	function automatic tab_t build_tab();
		tab_t t;
		longint unsigned iu;
		longint unsigned ku;
		longint unsigned u;
		longint unsigned term;
		longint sum;
		for (int i = 0; i <= EXP_TABLE_SIZE; i++) begin
			iu   = 64'(i);
			u    = udiv(iu << 30, 64'(EXP_TABLE_SIZE));
			term = 64'd1 << 30;
			sum  = 64'sd1 <<< 30;
			for (int k = 1; k < 25; k++) begin
				ku   = 64'(k);
				term = udiv((term * u) >> 30, ku);
				if (k[0])
					sum = sum - signed'(term);
				else
					sum = sum + signed'(term);
			end
			t[i] = 17'((unsigned'(sum) + 64'd8192) >> 14);
		end
		return t;
	endfunction

	localparam tab_t EXP_TAB = build_tab();

	// Registers
	logic signed [TW-1:0]          ambient_q, limit_q, temp_q;
	logic [ects_pkg::RATE_W-1:0]   heat_rate_q, cool_rate_q;
	logic [ects_pkg::SPEED_W-1:0]  idle_q, redline_q, speed_q;
	logic [ects_pkg::THR_W-1:0]    thr_q;
	logic [ects_pkg::STEP_W-1:0]   step_q;
	logic                          flag_q;
	logic [13:0]                   rem_q;
	logic [16:0]                   load_q, l2_q, h_q, heat_q, e0_q, rom_q, f_q;
	logic [17:0]                   lt_q;
	logic [31:0]                   acc_q;
	logic [PW-1:0]                 prod_q;
	logic [AW-1:0]                 idx_q;
	logic [15:0]                   g_q;
	logic signed [19:0]            excess_q;
	logic signed [TW-1:0]          out_temp_q;
	logic                          out_flag_q;

	// Load terms
	logic signed [14:0] num_c, den_raw_c;
	logic [13:0]        den_c;
	logic               num_pos_c, num_ge_c;
	logic [14:0]        rem_sh_c;

	always_comb begin
		num_c     = $signed({1'b0, speed_q}) - $signed({1'b0, idle_q});
		den_raw_c = $signed({1'b0, redline_q}) - $signed({1'b0, idle_q});
		den_c     = (den_raw_c < 15'sd1) ? 14'd1 : den_raw_c[13:0];
		num_pos_c = num_c > 15'sd0;
		num_ge_c  = num_c[13:0] >= den_c;
		rem_sh_c  = {rem_q, 1'b0};
	end

	assign status.step_zero = (step_q == '0);
	assign status.need_div  = num_pos_c && !num_ge_c;

	// Shared multiplier
	logic [ects_pkg::MUL_A_W-1:0] mul_a;
	logic [ects_pkg::MUL_B_W-1:0] mul_b;
	logic [PW-1:0]                prod_c;
	logic [16:0]                  diff_c;

	assign diff_c = e0_q - rom_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			ects_pkg::OP_LL: begin
				mul_a = 32'(load_q); mul_b = 18'(load_q);
			end
			ects_pkg::OP_LT: begin
				mul_a = 32'(load_q); mul_b = 18'(thr_q);
			end
			ects_pkg::OP_H0: begin
				mul_a = ects_pkg::K_LOAD_SQ; mul_b = 18'(l2_q);
			end
			ects_pkg::OP_H1: begin
				mul_a = ects_pkg::K_LOAD_THR; mul_b = lt_q;
			end
			ects_pkg::OP_SR: begin
				mul_a = 32'(step_q); mul_b = 18'(heat_rate_q);
			end
			ects_pkg::OP_HT: begin
				mul_a = prod_q[31:0]; mul_b = 18'(h_q);
			end
			ects_pkg::OP_X: begin
				mul_a = 32'(cool_rate_q); mul_b = 18'(step_q);
			end
			ects_pkg::OP_P: begin
				mul_a = prod_q[31:0]; mul_b = 18'(EXP_TABLE_SIZE);
			end
			ects_pkg::OP_DIFF: begin
				mul_a = 32'(diff_c); mul_b = 18'(g_q);
			end
			ects_pkg::OP_DEC: begin
				mul_a = 32'(excess_q[18:0]); mul_b = 18'(f_q);
			end
			default: ;
		endcase
	end

	assign prod_c = PW'(mul_a) * PW'(mul_b);

	// Table read, registered
	logic [AW-1:0] rom_addr;
	assign rom_addr = (op == ects_pkg::OP_ROM1) ? idx_q + 1'b1 : prod_q[32 +: AW];

	always_ff @(posedge clk) begin
		rom_q <= EXP_TAB[rom_addr];
	end

	// Post-product terms
	logic [PW-1:0]      heat_sum_c, rnd_c;
	logic [32:0]        h_sum_c;
	logic signed [22:0] new_temp_c;
	logic signed [19:0] band_c;

	always_comb begin
		heat_sum_c = prod_q + (PW'(1) << 31);
		rnd_c      = prod_q + (PW'(1) << 15);
		h_sum_c    = 33'(acc_q) + prod_q[32:0];
		new_temp_c = 23'(ambient_q) + $signed({2'b00, rnd_c[36:16]});
		band_c     = 20'(limit_q) - HYST;
	end

	// Payload
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		case (op)
			ects_pkg::OP_CAPTURE: begin
				speed_q <= engine_speed;
				thr_q   <= throttle_pos;
				step_q  <= step_time;
			end
			ects_pkg::OP_SETUP: begin
				rem_q  <= num_c[13:0];
				load_q <= (num_pos_c && num_ge_c) ? 17'h10000 : 17'd0;
			end
			ects_pkg::OP_DIV: begin
				if (rem_sh_c >= {1'b0, den_c}) begin
					rem_q  <= 14'(rem_sh_c - {1'b0, den_c});
					load_q <= {load_q[15:0], 1'b1};
				end else begin
					rem_q  <= rem_sh_c[13:0];
					load_q <= {load_q[15:0], 1'b0};
				end
			end
			ects_pkg::OP_LT:   l2_q   <= prod_q[32:16];
			ects_pkg::OP_H0:   lt_q   <= prod_q[32:15];
			ects_pkg::OP_H1:   acc_q  <= prod_q[31:0];
			ects_pkg::OP_SR:   h_q    <= h_sum_c[32:16];
			ects_pkg::OP_X:    heat_q <= heat_sum_c[48:32];
			ects_pkg::OP_ROM0: begin
				idx_q    <= prod_q[32 +: AW];
				g_q      <= prod_q[31:16];
				excess_q <= 20'(temp_q) + $signed({3'b000, heat_q}) - 20'(ambient_q);
			end
			ects_pkg::OP_ROM1: e0_q <= rom_q;
			ects_pkg::OP_FRAC: f_q  <= e0_q - rnd_c[32:16];
			ects_pkg::OP_OUT: begin
				out_temp_q <= temp_q;
				out_flag_q <= flag_q;
			end
			default: ;
		endcase
	end

	// Configuration and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q   <= ects_pkg::AMBIENT_RST;
			heat_rate_q <= ects_pkg::HEAT_RST;
			cool_rate_q <= ects_pkg::COOL_RST;
			limit_q     <= ects_pkg::LIMIT_RST;
			idle_q      <= ects_pkg::IDLE_RST;
			redline_q   <= ects_pkg::REDLINE_RST;
			temp_q      <= ects_pkg::AMBIENT_RST;
			flag_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					ects_pkg::REG_AMBIENT: begin
						ambient_q <= $signed(cfg_data);
						temp_q    <= $signed(cfg_data);
					end
					ects_pkg::REG_HEAT:    heat_rate_q <= cfg_data[15:0];
					ects_pkg::REG_COOL:    cool_rate_q <= cfg_data[15:0];
					ects_pkg::REG_LIMIT:   limit_q     <= $signed(cfg_data);
					ects_pkg::REG_IDLE:    idle_q      <= cfg_data[13:0];
					ects_pkg::REG_REDLINE: redline_q   <= cfg_data[13:0];
					default: ;
				endcase
			end
			if (op == ects_pkg::OP_UPD) begin
				if (excess_q <= 20'sd0)
					temp_q <= ambient_q;
				else if (new_temp_c > 23'(ects_pkg::TEMP_TOP))
					temp_q <= ects_pkg::TEMP_TOP;
				else
					temp_q <= new_temp_c[TW-1:0];
			end
			if (op == ects_pkg::OP_FLAG) begin
				if (temp_q >= limit_q)
					flag_q <= 1'b1;
				else if (20'(temp_q) < band_c)
					flag_q <= 1'b0;
			end
		end
	end

	assign coolant_temp  = out_temp_q;
	assign overheat_flag = out_flag_q;

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		op == ects_pkg::OP_LL |-> load_q <= 17'h10000)
		else $error("load above full scale");

	a_temp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		op == ects_pkg::OP_UPD |=> temp_q >= ambient_q)
		else $error("temperature below ambient after step");

	a_table_order: assert property (@(posedge clk) disable iff (!arst_n)
		op == ects_pkg::OP_DIFF |-> e0_q >= rom_q)
		else $error("decay table not descending");

endmodule

// ===== design/engine_coolant_thermal_step_top.sv =====
// ----------------------------------------------------------------------------
// Engine coolant thermal step
// Coolant temperature model: load, heat input, exponential decay, overheat.
// ----------------------------------------------------------------------------
//  channel  dir  fields                                    handshake
//  sample   in   engine_speed, throttle_pos, step_time     valid/ready
//  result   out  coolant_temp, overheat_flag               valid/ready
//  cfg      in   addr (register index), data               valid/ready
//
//  The load divider runs only when the engine speed falls strictly between
//  idle and redline; a zero step goes straight from setup to the output state.
//  One 32x18 multiplier is shared by every product.
//  Reset restores the configuration registers, temperature and flag to their defaults; no clearing pass.
//  A result waits in the output register; the next sample is accepted and
//  computed meanwhile, and the controller holds in its output state until
//  the waiting result is taken.
// ----------------------------------------------------------------------------
module engine_coolant_thermal_step_top #(
	parameter int EXP_TABLE_SIZE = 256,
	parameter int TEMP_FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	ects_sample_if.sink   sample,
	ects_result_if.source result,
	ects_cfg_if.sink      cfg
);

	ects_pkg::op_t      op;
	ects_pkg::status_t  status;

	// Register writes are taken at any time; the host is to write only when idle, which the block does not enforce.
	assign cfg.ready = 1'b1;

	// Controller: one state per datapath operation
	ects_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.op        (op)
	);

	// Datapath: registers, divider, multiplier, decay table
	ects_dp #(
		.EXP_TABLE_SIZE (EXP_TABLE_SIZE),
		.TEMP_FRAC_BITS (TEMP_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.status        (status),
		.engine_speed  (sample.engine_speed),
		.throttle_pos  (sample.throttle_pos),
		.step_time     (sample.step_time),
		.cfg_we        (cfg.valid),
		.cfg_addr      (cfg.addr),
		.cfg_data      (cfg.data),
		.coolant_temp  (result.coolant_temp),
		.overheat_flag (result.overheat_flag)
	);

endmodule

// ===== tb/ects_tb_if.sv =====
// ----------------------------------------------------------------------------
// Coolant step testbench channel note
// The channel interfaces come from the design file set; this package holds only the sample and result structs.
// ----------------------------------------------------------------------------
package ects_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [13:0] engine_speed;
		logic [15:0] throttle_pos;
		logic [15:0] step_time;
	} sample_t;

	typedef struct packed {
		logic signed [16:0] coolant_temp;
		logic               overheat_flag;
	} temp_result_t;
endpackage

// ===== tb/tb_engine_coolant_thermal_step_top.sv =====
// ----------------------------------------------------------------------------
// Engine coolant thermal step testbench
// Drives time steps and register writes with random idling and back-pressure.
// A built-in coolant model predicts each temperature and flag, and every
// result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_engine_coolant_thermal_step_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	ects_sample_if sample ();
	ects_result_if result ();
	ects_cfg_if    cfg ();

	engine_coolant_thermal_step_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------- coolant model ----------------
	localparam int TAB_N = 256;
	longint exp_q16 [0:TAB_N];

	longint amb_c, heat_c, cool_c, limit_c, idle_c, red_c;
	longint coolant_c;
	bit     hot_c;

	ects_tb_pkg::temp_result_t expected_temps [$];
	ects_tb_pkg::sample_t      pending_samples [$];

	int errors;
	bit hold_start;     // long receiver hold-off request
	int hold_cnt;       // hold-off cycles left
	bit calm;           // no-idling stretch

	// exp(-i/256) in Q16 via truncated Taylor series in Q30
	function automatic void build_exp_q16();
		longint u, term, acc;
		for (int i = 0; i <= TAB_N; i++) begin
			u = (longint'(i) << 30) / TAB_N;
			term = 64'd1 << 30;
			acc = term;
			for (int k = 1; k < 25; k++) begin
				term = ((term * u) >>> 30) / k;
				if (k % 2) acc -= term;
				else acc += term;
			end
			exp_q16[i] = (acc + (1 << 13)) >>> 14;
		end
	endfunction

	function automatic longint sext17(logic [16:0] v);
		return longint'($signed(v));
	endfunction

	function automatic void write_coolant_reg(logic [2:0] idx, logic [16:0] v);
		case (idx)
			ects_pkg::REG_AMBIENT: begin
				amb_c = sext17(v);
				coolant_c = amb_c;
			end
			ects_pkg::REG_HEAT:    heat_c = v[15:0];
			ects_pkg::REG_COOL:    cool_c = v[15:0];
			ects_pkg::REG_LIMIT:   limit_c = sext17(v);
			ects_pkg::REG_IDLE:    idle_c = v[13:0];
			ects_pkg::REG_REDLINE: red_c = v[13:0];
			default: ;
		endcase
	endfunction

	// Advance the coolant model one step and return the emitted values
	function automatic ects_tb_pkg::temp_result_t step_coolant(ects_tb_pkg::sample_t s);
		longint num, den, load, l2, lt, h, heat, x, p, g, d, f, excess;
		longint unsigned prod;
		int idx;
		ects_tb_pkg::temp_result_t r;
		if (s.step_time != 0) begin
			num = longint'(s.engine_speed) - idle_c;
			den = red_c - idle_c;
			if (den < 1) den = 1;
			load = 0;
			if (num > 0) load = (num >= den) ? 65536 : (num << 16) / den;
			l2 = (load * load) >> 16;
			lt = (load * longint'(s.throttle_pos)) >> 15;
			h = (19661 * l2 + 45875 * lt) >> 16;
			// step*rate*h fits in 49 bits; use unsigned
			prod = longint'(s.step_time) * heat_c;
			prod = prod * longint'(h) + (64'd1 << 31);
			heat = longint'(prod >> 32);
			x = cool_c * longint'(s.step_time);
			p = x * TAB_N;
			idx = int'(p >> 32);
			if (idx >= TAB_N) idx = TAB_N - 1;
			g = (p & 64'hFFFF_FFFF) >> 16;
			d = exp_q16[idx] - exp_q16[idx + 1];
			f = exp_q16[idx] - ((d * g + 32768) >> 16);
			excess = coolant_c + heat - amb_c;
			if (excess <= 0) coolant_c = amb_c;
			else begin
				coolant_c = amb_c + ((excess * f + 32768) >> 16);
				if (coolant_c > 65535) coolant_c = 65535;
			end
			if (coolant_c >= limit_c) hot_c = 1'b1;
			else if (coolant_c < limit_c - (5 << 8)) hot_c = 1'b0;
		end
		r.coolant_temp = coolant_c[16:0];
		r.overheat_flag = hot_c;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// handshake flags captured at the rising edge
	bit sample_taken;
	always @(posedge clk) sample_taken <= sample.valid && sample.ready;

	// ---------------- sample driver ----------------
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.engine_speed <= '0;
			sample.throttle_pos <= '0;
			sample.step_time <= '0;
		end else begin
			if (!sample.valid || sample_taken) begin
				if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
					ects_tb_pkg::sample_t s;
					s = pending_samples.pop_front();
					sample.valid <= 1'b1;
					{sample.engine_speed, sample.throttle_pos, sample.step_time} <= s;
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------
	always @(posedge clk) begin
		if (arst_n && sample.valid && sample.ready)
			expected_temps.push_back(step_coolant(
				{sample.engine_speed, sample.throttle_pos, sample.step_time}));
		if (arst_n && result.valid && result.ready) begin
			if (expected_temps.size() == 0) begin
				report_mismatch("unexpected result", result.coolant_temp, 0);
			end else begin
				ects_tb_pkg::temp_result_t e;
				e = expected_temps.pop_front();
				if (result.coolant_temp !== e.coolant_temp)
					report_mismatch("coolant_temp", result.coolant_temp, e.coolant_temp);
				if (result.overheat_flag !== e.overheat_flag)
					report_mismatch("overheat_flag", result.overheat_flag, e.overheat_flag);
			end
		end
	end

	// long hold-off, counted in cycles
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) hold_cnt <= 0;
		else if (hold_start) hold_cnt <= 400;
		else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 25);
	end

	// ---------------- configuration writes ----------------
	task automatic write_reg(logic [2:0] idx, logic [16:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		write_coolant_reg(idx, v);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || sample.valid || expected_temps.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic ects_tb_pkg::sample_t rand_sample();
		ects_tb_pkg::sample_t s;
		int m;
		m = $urandom_range(9);
		s.engine_speed = (m < 6) ? 14'($urandom_range(7000)) : 14'($urandom_range(16383));
		s.throttle_pos = (m < 8) ? 16'($urandom_range(32768)) : 16'($urandom_range(65535));
		case ($urandom_range(9))
			0: s.step_time = 16'd0;
			1: s.step_time = 16'($urandom_range(65535));
			default: s.step_time = 16'($urandom_range(4000));
		endcase
		return s;
	endfunction

	task automatic random_phase(int n);
		repeat (n) pending_samples.push_back(rand_sample());
	endtask

	// ---------------- stimulus ----------------
	initial begin
		errors = 0;
		hold_start = 0;
		calm = 0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = '0;
		cfg.data = '0;
		amb_c = 5120; heat_c = 512; cool_c = 1311; limit_c = 28160;
		idle_c = 800; red_c = 6500; coolant_c = 5120; hot_c = 0;
		build_exp_q16();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, zero step, over-full throttle
		pending_samples.push_back('{14'd0, 16'd0, 16'd0});
		pending_samples.push_back('{14'd16383, 16'd32768, 16'd65535});
		pending_samples.push_back('{14'd16383, 16'd65535, 16'd65535});
		pending_samples.push_back('{14'd16383, 16'd65535, 16'd0});
		pending_samples.push_back('{14'd3000, 16'd20000, 16'd1});
		pending_samples.push_back('{14'd800, 16'd65535, 16'd30000});
		pending_samples.push_back('{14'd801, 16'd32768, 16'd65535});
		pending_samples.push_back('{14'd6499, 16'd0, 16'd65535});
		pending_samples.push_back('{14'd0, 16'd0, 16'd65535});
		drain();

		// hot engine: low limit, high heat, then hysteresis band cooling
		write_reg(ects_pkg::REG_HEAT, 17'd65535);
		write_reg(ects_pkg::REG_COOL, 17'd0);
		write_reg(ects_pkg::REG_LIMIT, 17'd6000);
		repeat (6) pending_samples.push_back('{14'd7000, 16'd32768, 16'd2000});
		drain();
		write_reg(ects_pkg::REG_HEAT, 17'd0);
		write_reg(ects_pkg::REG_COOL, 17'd65535);
		repeat (6) pending_samples.push_back('{14'd0, 16'd0, 16'd4000});
		pending_samples.push_back('{14'd0, 16'd0, 16'd65535});
		drain();

		// defaults, receiver hold-off so the block backs up
		write_reg(ects_pkg::REG_AMBIENT, 17'd5120);
		write_reg(ects_pkg::REG_HEAT, 17'd512);
		write_reg(ects_pkg::REG_COOL, 17'd1311);
		write_reg(ects_pkg::REG_LIMIT, 17'd28160);
		write_reg(ects_pkg::REG_IDLE, 17'd800);
		write_reg(ects_pkg::REG_REDLINE, 17'd6500);
		calm = 1;
		@(posedge clk);
		hold_start = 1;
		@(posedge clk);
		hold_start = 0;
		random_phase(20);
		while (hold_cnt != 0) @(posedge clk);
		calm = 0;
		random_phase(150);
		drain();

		// extremes: minimum ambient, redline below idle, max rates
		write_reg(ects_pkg::REG_AMBIENT, 17'h1C000);
		write_reg(ects_pkg::REG_LIMIT, 17'h1C000);
		write_reg(ects_pkg::REG_IDLE, 17'd16383);
		write_reg(ects_pkg::REG_REDLINE, 17'd0);
		write_reg(ects_pkg::REG_HEAT, 17'd65535);
		write_reg(ects_pkg::REG_COOL, 17'd65535);
		write_reg(3'd7, 17'h1FFFF);
		random_phase(100);
		drain();

		// top ambient, idle at zero, equal idle and redline
		write_reg(ects_pkg::REG_AMBIENT, 17'd65535);
		write_reg(ects_pkg::REG_LIMIT, 17'd65535);
		write_reg(ects_pkg::REG_IDLE, 17'd0);
		write_reg(ects_pkg::REG_REDLINE, 17'd16383);
		calm = 1;
		random_phase(100);
		drain();
		calm = 0;
		write_reg(ects_pkg::REG_AMBIENT, 17'd0);
		write_reg(ects_pkg::REG_LIMIT, 17'd20000);
		write_reg(ects_pkg::REG_IDLE, 17'd3000);
		write_reg(ects_pkg::REG_REDLINE, 17'd3000);
		write_reg(ects_pkg::REG_HEAT, 17'd20000);
		write_reg(ects_pkg::REG_COOL, 17'd300);
		random_phase(120);
		drain();

		// random registers
		write_reg(ects_pkg::REG_AMBIENT, 17'($urandom_range(81919) - 16384));
		write_reg(ects_pkg::REG_LIMIT, 17'($urandom_range(81919) - 16384));
		write_reg(ects_pkg::REG_HEAT, 17'($urandom_range(65535)));
		write_reg(ects_pkg::REG_COOL, 17'($urandom_range(65535)));
		write_reg(ects_pkg::REG_IDLE, 17'($urandom_range(16383)));
		write_reg(ects_pkg::REG_REDLINE, 17'($urandom_range(16383)));
		random_phase(120);
		drain();

		if (errors == 0)
			$display("[engine_coolant_thermal_step_top] OK");
		else
			$display("[engine_coolant_thermal_step_top] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("[engine_coolant_thermal_step_top] ERROR");
		$finish;
	end

endmodule
